FILE: hw/rtl/msm_pkg.sv
// Package for the magic signature matcher: signature table, types and constants.
package msm_pkg;

  localparam int SIG_MAX_LEN = 20;
  localparam int SIG_PAT_W = 8 * SIG_MAX_LEN;
  localparam int IDX_W = 5;
  localparam int LEN_W = 5;
  localparam int OFF_W = 8;
  localparam int FMT_W = 4;
  localparam int CONF_W = 2;
  localparam int TDATA_W = 16;

  localparam logic [FMT_W-1:0] FMT_UNKNOWN = 4'd0;
  localparam logic [FMT_W-1:0] FMT_JPEG = 4'd1;
  localparam logic [FMT_W-1:0] FMT_PNG = 4'd2;
  localparam logic [FMT_W-1:0] FMT_BMP = 4'd3;
  localparam logic [FMT_W-1:0] FMT_TIFF = 4'd4;
  localparam logic [FMT_W-1:0] FMT_GIF = 4'd5;
  localparam logic [FMT_W-1:0] FMT_WEBP = 4'd6;
  localparam logic [FMT_W-1:0] FMT_AVIF = 4'd7;
  localparam logic [FMT_W-1:0] FMT_HEIF = 4'd8;
  localparam logic [FMT_W-1:0] FMT_PSD = 4'd9;
  localparam logic [FMT_W-1:0] FMT_HDR = 4'd10;
  localparam logic [FMT_W-1:0] FMT_EXR = 4'd11;
  localparam logic [FMT_W-1:0] FMT_FITS = 4'd12;
  localparam logic [FMT_W-1:0] FMT_SER = 4'd13;
  localparam logic [FMT_W-1:0] FMT_DICOM = 4'd14;

  localparam logic [CONF_W-1:0] CONF_NONE = 2'd0;
  localparam logic [CONF_W-1:0] CONF_HIGH = 2'd1;
  localparam logic [CONF_W-1:0] CONF_CERTAIN = 2'd2;

  // The pattern is left aligned: byte k of the signature sits at bits
  // [8*(SIG_MAX_LEN-1-k) +: 8].
  typedef struct packed {
    logic [SIG_PAT_W-1:0] pat;
    logic [LEN_W-1:0]     len;
    logic [OFF_W-1:0]     off;
    logic [FMT_W-1:0]     fmt;
    logic [CONF_W-1:0]    conf;
  } sig_entry_t;

  typedef struct packed {
    logic              matched;
    logic [IDX_W-1:0]  index;
    logic [FMT_W-1:0]  fmt;
    logic [CONF_W-1:0] conf;
  } result_t;

  function automatic sig_entry_t sig_entry(input logic [IDX_W-1:0] idx);
    sig_entry_t e;
    e = '0;
    case (idx)
      5'd0: e = '{{8'hFF, 8'hD8, 8'hFF, 136'h0}, 5'd3, 8'd0, FMT_JPEG, CONF_CERTAIN};
      5'd1: e = '{{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A, 96'h0},
                  5'd8, 8'd0, FMT_PNG, CONF_CERTAIN};
      5'd2: e = '{{8'h42, 8'h4D, 144'h0}, 5'd2, 8'd0, FMT_BMP, CONF_CERTAIN};
      5'd3: e = '{{8'h49, 8'h49, 8'h2A, 8'h00, 128'h0}, 5'd4, 8'd0, FMT_TIFF, CONF_CERTAIN};
      5'd4: e = '{{8'h4D, 8'h4D, 8'h00, 8'h2A, 128'h0}, 5'd4, 8'd0, FMT_TIFF, CONF_CERTAIN};
      5'd5: e = '{{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61, 112'h0},
                  5'd6, 8'd0, FMT_GIF, CONF_CERTAIN};
      5'd6: e = '{{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 112'h0},
                  5'd6, 8'd0, FMT_GIF, CONF_CERTAIN};
      5'd7: e = '{{8'h52, 8'h49, 8'h46, 8'h46, 128'h0}, 5'd4, 8'd0, FMT_WEBP, CONF_HIGH};
      5'd8: e = '{{8'h57, 8'h45, 8'h42, 8'h50, 128'h0}, 5'd4, 8'd8, FMT_WEBP, CONF_CERTAIN};
      5'd9: e = '{{8'h66, 8'h74, 8'h79, 8'h70, 8'h61, 8'h76, 8'h69, 8'h66, 96'h0},
                  5'd8, 8'd4, FMT_AVIF, CONF_CERTAIN};
      5'd10: e = '{{8'h66, 8'h74, 8'h79, 8'h70, 8'h68, 8'h65, 8'h69, 8'h63, 96'h0},
                   5'd8, 8'd4, FMT_HEIF, CONF_CERTAIN};
      5'd11: e = '{{8'h38, 8'h42, 8'h50, 8'h53, 128'h0}, 5'd4, 8'd0, FMT_PSD, CONF_CERTAIN};
      5'd12: e = '{{8'h23, 8'h3F, 8'h52, 8'h41, 8'h44, 8'h49, 8'h41, 8'h4E, 8'h43, 8'h45,
                    8'h0A, 72'h0}, 5'd11, 8'd0, FMT_HDR, CONF_CERTAIN};
      5'd13: e = '{{8'h76, 8'h2F, 8'h31, 8'h01, 128'h0}, 5'd4, 8'd0, FMT_EXR, CONF_CERTAIN};
      5'd14: e = '{{8'h53, 8'h49, 8'h4D, 8'h50, 8'h4C, 8'h45, 8'h20, 8'h20, 8'h3D, 8'h20,
                    8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h54},
                   5'd20, 8'd0, FMT_FITS, CONF_CERTAIN};
      5'd15: e = '{{8'h4C, 8'h55, 8'h43, 8'h41, 8'h4D, 8'h2D, 8'h52, 8'h45, 8'h43, 8'h4F,
                    8'h52, 8'h44, 8'h45, 8'h52, 48'h0}, 5'd14, 8'd0, FMT_SER, CONF_CERTAIN};
      5'd16: e = '{{8'h44, 8'h49, 8'h43, 8'h4D, 128'h0}, 5'd4, 8'd128, FMT_DICOM,
                   CONF_CERTAIN};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

FILE: hw/rtl/msm_sig_compare.sv
// Per-signature byte compare: clears mismatching flags and flags complete matches.
module msm_sig_compare #(
  parameter int NUM_SIGNATURES = 17,
  parameter int POS_W = 10
) (
  input  logic [POS_W-1:0]          pos,
  input  logic [7:0]                byte_value,
  input  logic [NUM_SIGNATURES-1:0] flags,
  output logic [NUM_SIGNATURES-1:0] flags_upd,
  output logic [NUM_SIGNATURES-1:0] complete
);

  for (genvar i = 0; i < NUM_SIGNATURES; i++) begin : g_sig
    localparam msm_pkg::sig_entry_t Ent = msm_pkg::sig_entry(msm_pkg::IDX_W'(i));
    localparam logic [POS_W:0] OffX = (POS_W+1)'(Ent.off);
    localparam logic [POS_W:0] EndX = (POS_W+1)'(Ent.off) + (POS_W+1)'(Ent.len);

    logic [POS_W:0] pos_x;
    logic [POS_W:0] rel;
    logic [msm_pkg::LEN_W-1:0] sel;
    logic [7:0] pat_byte;
    logic in_win;
    logic mismatch;

    always_comb begin
      pos_x = {1'b0, pos};
      in_win = (pos_x >= OffX) && (pos_x < EndX);
      rel = pos_x - OffX;
      // Patterns are stored first byte highest, so reverse the offset.
      sel = msm_pkg::LEN_W'(msm_pkg::SIG_MAX_LEN - 1) - rel[msm_pkg::LEN_W-1:0];
      pat_byte = Ent.pat[{sel, 3'b000} +: 8];
      mismatch = in_win && (pat_byte != byte_value);
      flags_upd[i] = flags[i] & ~mismatch;
      complete[i] = flags_upd[i] && (Ent.len != '0) && (EndX <= pos_x + (POS_W+1)'(1));
    end
  end

endmodule

FILE: hw/rtl/msm_priority.sv
// Picks the first complete signature in table order and builds the result.
module msm_priority #(
  parameter int NUM_SIGNATURES = 17
) (
  input  logic [NUM_SIGNATURES-1:0] complete,
  output msm_pkg::result_t          result
);

  logic [msm_pkg::IDX_W-1:0] sel;
  logic any;
  msm_pkg::sig_entry_t ent;

  always_comb begin
    sel = '0;
    any = 1'b0;
    for (int i = NUM_SIGNATURES - 1; i >= 0; i--) begin
      if (complete[i]) begin
        sel = msm_pkg::IDX_W'(i);
        any = 1'b1;
      end
    end
    ent = msm_pkg::sig_entry(sel);
    result.matched = any;
    result.index = any ? sel : '0;
    result.fmt = any ? ent.fmt : msm_pkg::FMT_UNKNOWN;
    result.conf = any ? ent.conf : msm_pkg::CONF_NONE;
  end

endmodule

FILE: hw/rtl/magic_signature_matcher_core.sv
// Top level of the magic signature matcher: input register, match state, result register.
//
// Header bytes arrive one per beat on the slave stream, starting at file offset zero,
// with tlast on the final byte. Every byte is compared at once against all
// signatures of the built-in table, so the block takes one byte per clock. The only
// stall comes from the result side: a last byte waits in the input register while the
// previous result beat is still held by a low m_tready. The accepted last byte sits in
// the input register until the result register is free; the result is then registered
// from it, and the match state returns to its start at the same edge that registers
// the result.
module magic_signature_matcher_core #(
  parameter int NUM_SIGNATURES = 17,
  parameter int MAX_POSITION = 1023
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [msm_pkg::TDATA_W-1:0] m_tdata  // [0] matched, [5:1] signature_index,
                                 // [9:6] format_code, [11:10] confidence, [15:12] zero
);

  localparam int POS_W = $clog2(MAX_POSITION + 1);
  localparam logic [POS_W-1:0] PosMax = POS_W'(MAX_POSITION);

  logic                      in_full;
  logic [7:0]                in_byte;
  logic                      in_last;
  logic [POS_W-1:0]          pos;
  logic [NUM_SIGNATURES-1:0] flags;
  logic [NUM_SIGNATURES-1:0] flags_upd;
  logic [NUM_SIGNATURES-1:0] complete;
  msm_pkg::result_t          result;
  msm_pkg::result_t          out_res;
  logic                      out_free;
  logic                      advance;

  assign out_free = !m_tvalid || m_tready;
  assign advance = in_full && (!in_last || out_free);
  assign s_tready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  msm_sig_compare #(
    .NUM_SIGNATURES(NUM_SIGNATURES),
    .POS_W(POS_W)
  ) u_compare (
    .pos(pos),
    .byte_value(in_byte),
    .flags(flags),
    .flags_upd(flags_upd),
    .complete(complete)
  );

  msm_priority #(
    .NUM_SIGNATURES(NUM_SIGNATURES)
  ) u_priority (
    .complete(complete),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      flags <= '1;
    end else if (advance) begin
      if (in_last) begin
        pos <= '0;
        flags <= '1;
      end else begin
        flags <= flags_upd;
        if (pos < PosMax) begin
          pos <= pos + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance && in_last) begin
      out_res <= result;
    end
  end

  assign m_tdata = {4'b0000, out_res.conf, out_res.fmt, out_res.index, out_res.matched};

endmodule

FILE: hw/rtl/msm_checker.sv
// Port-level checker for the magic signature matcher, bound to the top level.
module msm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // A stalled result beat keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // An unknown result carries zero index, format and confidence.
  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[11:1] == 11'd0)
    else $error("unknown result with nonzero fields");

  // A match always names a format and a nonzero confidence, and padding stays zero.
  a_match_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[9:6] != 4'd0 && m_tdata[11:10] != 2'd0
                               && m_tdata[15:12] == 4'd0)
    else $error("matched result with empty format or confidence");

  // Right after reset no result is pending and the input is open.
  a_reset_state: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid && s_tready)
    else $error("block not idle after reset");

endmodule

bind magic_signature_matcher_core msm_checker u_msm_checker (.*);
